// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define STC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("stc assertion failed");
`define STC_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("stc forbidden condition seen");
`else
`define STC_ASSERT(name, clk, rst_n, prop)
`define STC_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/stc_pkg.sv =====
`default_nettype none

package stc_pkg;

  localparam int unsigned LevelW   = 2;
  localparam int unsigned SleepW   = 16;
  localparam int unsigned StepW    = 12;
  localparam int unsigned DispW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [SleepW-1:0] SleepTicksRst = 16'd6000;
  localparam logic [StepW-1:0]  MaxStepsRst   = 12'd600;

  localparam logic [LevelW-1:0] LIGHT_DARK = 2'd0;
  localparam logic [LevelW-1:0] LIGHT_LOW  = 2'd1;

  localparam logic [CfgIdxW-1:0] CFG_SLEEP_TICKS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_STEPS   = 2'd1;

  typedef enum logic [1:0] {
    MODE_LOW    = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_DARK   = 2'd2
  } mode_e;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic  motor_on;
    logic  motor_toward_two;
    logic  lamp_on;
    mode_e panel_mode;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stc_state.sv =====
`default_nettype none

module stc_state (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  stc_pkg::cfg_wr_t             cfg_i,
  input  wire                          step_i,
  input  wire  [stc_pkg::LevelW-1:0]   level_i,
  input  wire                          two_i,
  output stc_pkg::result_t             result_o
);
  import stc_pkg::*;

  localparam int unsigned SumW = DispW + 2;
  localparam logic signed [SumW-1:0] DispMax = SumW'(32767);
  localparam logic signed [SumW-1:0] DispMin = -SumW'(32768);

  logic [SleepW-1:0] sleep_ticks_q;
  logic [StepW-1:0]  max_steps_q;

  mode_e             mode_q, mode_d;
  logic              running_q, running_d;
  logic              dir_q, dir_d;
  logic [StepW-1:0]  steps_left_q, steps_left_d;
  logic [StepW-1:0]  steps_done_q, steps_done_d;
  logic [DispW-1:0]  disp_q, disp_d;
  logic [SleepW-1:0] sleep_left_q, sleep_left_d;
  logic              lamp_q, lamp_d;

  logic              normal_light;
  logic              fin;
  logic              start;
  logic              start_dir;
  logic              clear_disp;
  logic [StepW-1:0]  fin_cnt;
  logic [DispW-1:0]  disp_base;
  logic signed [SumW-1:0] delta;
  logic signed [SumW-1:0] sum;

  assign normal_light = (level_i != LIGHT_DARK) && (level_i != LIGHT_LOW);

  always_comb begin
    mode_d       = mode_q;
    running_d    = running_q;
    dir_d        = dir_q;
    steps_left_d = steps_left_q;
    steps_done_d = steps_done_q;
    disp_d       = disp_q;
    sleep_left_d = sleep_left_q;
    lamp_d       = lamp_q;
    fin          = 1'b0;
    start        = 1'b0;
    start_dir    = 1'b0;
    clear_disp   = 1'b0;
    fin_cnt      = steps_done_q;
    delta        = '0;
    sum          = '0;

    if (running_q) begin
      if (normal_light && (two_i != dir_q)) begin
        // sun side flipped: stop without a step
        fin = 1'b1;
      end else begin
        if (steps_left_q != '0) begin
          steps_left_d = steps_left_q - StepW'(1);
        end
        steps_done_d = steps_done_q + StepW'(1);
        fin_cnt      = steps_done_d;
        fin          = (steps_left_d == '0);
      end
    end else if (sleep_left_q != '0) begin
      sleep_left_d = sleep_left_q - SleepW'(1);
    end else begin
      unique case (mode_q)
        MODE_NORMAL: begin
          lamp_d = 1'b0;
          if (level_i == LIGHT_DARK) begin
            mode_d = MODE_DARK;
          end else if (level_i == LIGHT_LOW) begin
            mode_d = MODE_LOW;
          end else begin
            start     = 1'b1;
            start_dir = two_i;
          end
        end
        MODE_LOW: begin
          lamp_d = 1'b0;
          if (level_i == LIGHT_DARK) begin
            mode_d = MODE_DARK;
          end else if (level_i != LIGHT_LOW) begin
            mode_d = MODE_NORMAL;
          end
        end
        default: begin
          lamp_d = 1'b1;
          if (level_i == LIGHT_LOW) begin
            // sunrise return: head back against the accumulated offset
            start      = 1'b1;
            start_dir  = ~disp_q[DispW-1];
            clear_disp = 1'b1;
            mode_d     = MODE_LOW;
          end else if (level_i != LIGHT_DARK) begin
            mode_d = MODE_NORMAL;
          end
        end
      endcase

      if (start) begin
        running_d    = 1'b1;
        dir_d        = start_dir;
        steps_left_d = max_steps_q;
        steps_done_d = '0;
        if (clear_disp) begin
          disp_d = '0;
        end
        if (max_steps_q == '0) begin
          fin     = 1'b1;
          fin_cnt = '0;
        end
      end else begin
        sleep_left_d = sleep_ticks_q;
      end
    end

    if (fin) begin
      disp_base = disp_d;
      delta     = dir_d ? -$signed(SumW'(fin_cnt)) : $signed(SumW'(fin_cnt));
      sum       = $signed({{(SumW-DispW){disp_base[DispW-1]}}, disp_base}) + delta;
      if (sum > DispMax) begin
        disp_d = DispW'(DispMax);
      end else if (sum < DispMin) begin
        disp_d = DispW'(DispMin);
      end else begin
        disp_d = sum[DispW-1:0];
      end
      running_d    = 1'b0;
      steps_left_d = '0;
      steps_done_d = '0;
      sleep_left_d = sleep_ticks_q;
    end else begin
      disp_base = disp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_ticks_q <= SleepTicksRst;
      max_steps_q   <= MaxStepsRst;
    end else if (cfg_i.we) begin
      priority if (cfg_i.idx == CFG_SLEEP_TICKS) begin
        sleep_ticks_q <= cfg_i.data[SleepW-1:0];
      end else if (cfg_i.idx == CFG_MAX_STEPS) begin
        max_steps_q <= cfg_i.data[StepW-1:0];
      end else begin
        // unknown index: drop the write
        sleep_ticks_q <= sleep_ticks_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_NORMAL;
      running_q    <= 1'b0;
      dir_q        <= 1'b0;
      steps_left_q <= '0;
      steps_done_q <= '0;
      disp_q       <= '0;
      sleep_left_q <= '0;
      lamp_q       <= 1'b1;
    end else if (step_i) begin
      mode_q       <= mode_d;
      running_q    <= running_d;
      dir_q        <= dir_d;
      steps_left_q <= steps_left_d;
      steps_done_q <= steps_done_d;
      disp_q       <= disp_d;
      sleep_left_q <= sleep_left_d;
      lamp_q       <= lamp_d;
    end
  end

  assign result_o.motor_on         = running_d;
  assign result_o.motor_toward_two = dir_d;
  assign result_o.lamp_on          = lamp_d;
  assign result_o.panel_mode       = mode_d;

endmodule

`default_nettype wire

// ===== hw/rtl/solar_tracker_mode_controller_core.sv =====
// A tick goes into the input register and, once the result register is free or
// draining, on into it; the tracker state updates as the tick moves on.
// Throughput: one tick per cycle while not stalled; each register holds one tick.
// Reset (rst_ni low, asynchronous): both registers empty, mode normal,
// lamp on, motor off, registers sleep_ticks=6000 and max_steps=600.
`default_nettype none
`include "assert_macros.svh"

module solar_tracker_mode_controller_core (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [stc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [stc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire                           in_vld_i,
  output logic                          in_stall_o,
  input  wire  [stc_pkg::LevelW-1:0]    light_level_i,
  input  wire                           sun_on_cell_two_i,
  output logic                          out_vld_o,
  input  wire                           out_stall_i,
  output logic                          motor_on_o,
  output logic                          motor_toward_two_o,
  output logic                          lamp_on_o,
  output logic [1:0]                    panel_mode_o
);
  import stc_pkg::*;

  logic              in_vld_q;
  logic [LevelW-1:0] in_level_q;
  logic              in_two_q;
  logic              out_vld_q;
  result_t           res_d, res_q;
  cfg_wr_t           cfg;
  logic              in_take;
  logic              advance;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  // move a tick into the result register when that slot is free or draining
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_vld_i && !in_stall_o;

  stc_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .level_i  (in_level_q),
    .two_i    (in_two_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_level_q <= light_level_i;
      in_two_q   <= sun_on_cell_two_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_vld_o          = out_vld_q;
  assign motor_on_o         = res_q.motor_on;
  assign motor_toward_two_o = res_q.motor_toward_two;
  assign lamp_on_o          = res_q.lamp_on;
  assign panel_mode_o       = res_q.panel_mode;

  // a rotation never runs while the panel sits in dark mode
  `STC_ASSERT_NEVER(a_no_motor_in_dark, clk_i, rst_ni,
    out_vld_o && motor_on_o && (panel_mode_o == MODE_DARK))
  // a held input transaction stays until it moves on
  `STC_ASSERT(a_in_held, clk_i, rst_ni, (in_vld_q && !advance) |=> in_vld_q)
  // a taken result with nothing behind it leaves the output empty
  `STC_ASSERT(a_out_drain, clk_i, rst_ni,
    (out_vld_o && !out_stall_i && !in_vld_q) |=> !out_vld_o)

endmodule

`default_nettype wire

// ===== sim/solar_tracker_mode_controller_core_tb.sv =====
module solar_tracker_mode_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stc_pkg::*;

  localparam logic [LevelW-1:0]  LIGHT_NORMAL = 2'd2;
  localparam logic [LevelW-1:0]  LIGHT_BRIGHT = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned PHASE_TICKS     = 80;
  localparam int unsigned STEADY_TICKS    = 60;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned HOLD_OFF_AFTER  = 150;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES    = 8;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_vld_i;
  logic                in_stall_o;
  logic [LevelW-1:0]   light_level_i;
  logic                sun_on_cell_two_i;
  logic                out_vld_o;
  logic                out_stall_i;
  logic                motor_on_o;
  logic                motor_toward_two_o;
  logic                lamp_on_o;
  logic [1:0]          panel_mode_o;

  solar_tracker_mode_controller_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_vld_i           (in_vld_i),
    .in_stall_o         (in_stall_o),
    .light_level_i      (light_level_i),
    .sun_on_cell_two_i  (sun_on_cell_two_i),
    .out_vld_o          (out_vld_o),
    .out_stall_i        (out_stall_i),
    .motor_on_o         (motor_on_o),
    .motor_toward_two_o (motor_toward_two_o),
    .lamp_on_o          (lamp_on_o),
    .panel_mode_o       (panel_mode_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Tracker state mirrored in the testbench.
  logic [SleepW-1:0] set_sleep_ticks;
  logic [StepW-1:0]  set_max_steps;
  mode_e             trk_mode;
  logic              trk_running;
  logic              trk_dir;
  logic              trk_lamp;
  logic [StepW-1:0]  trk_steps_left;
  logic [StepW-1:0]  trk_steps_done;
  int                trk_disp;
  logic [SleepW-1:0] trk_sleep_left;

  result_t     expected_status_q[$];
  int unsigned errors;
  int unsigned ticks_sent;
  int unsigned statuses_seen;
  int unsigned rotations;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  logic        held_once;
  logic        steady;
  logic [LevelW-1:0] drift_level;
  logic              drift_two;

  typedef enum logic {ROW_TICKS, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [LevelW-1:0]   level;
    logic                two;
    int unsigned         count;
    logic                typed;
    result_t             res;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } plan_row_t;

  plan_row_t plan_q[$];

  function automatic void end_rotation();
    int moved;
    moved = trk_dir ? trk_disp - int'(trk_steps_done) : trk_disp + int'(trk_steps_done);
    if (moved > 32767) moved = 32767;
    if (moved < -32768) moved = -32768;
    trk_disp       = moved;
    trk_running    = 1'b0;
    trk_steps_done = '0;
    trk_steps_left = '0;
    trk_sleep_left = set_sleep_ticks;
  endfunction

  function automatic void begin_rotation(input logic dir);
    trk_dir        = dir;
    trk_steps_left = set_max_steps;
    trk_steps_done = '0;
    trk_running    = 1'b1;
    rotations++;
    if (trk_steps_left == 0) end_rotation();
  endfunction

  function automatic result_t track_tick(input logic [LevelW-1:0] level, input logic two);
    logic normal_light;
    logic started;
    logic sunrise_dir;
    normal_light = (level != LIGHT_DARK) && (level != LIGHT_LOW);
    started      = 1'b0;
    if (trk_running) begin
      // a flip of the sun side in normal light stops without a step
      if (normal_light && two != trk_dir) begin
        end_rotation();
      end else begin
        if (trk_steps_left != 0) trk_steps_left--;
        trk_steps_done++;
        if (trk_steps_left == 0) end_rotation();
      end
    end else if (trk_sleep_left != 0) begin
      trk_sleep_left--;
    end else begin
      case (trk_mode)
        MODE_NORMAL: begin
          trk_lamp = 1'b0;
          if (level == LIGHT_DARK) trk_mode = MODE_DARK;
          else if (level == LIGHT_LOW) trk_mode = MODE_LOW;
          else begin
            begin_rotation(two);
            started = 1'b1;
          end
        end
        MODE_LOW: begin
          trk_lamp = 1'b0;
          if (level == LIGHT_DARK) trk_mode = MODE_DARK;
          else if (level != LIGHT_LOW) trk_mode = MODE_NORMAL;
        end
        default: begin
          trk_lamp = 1'b1;
          if (level == LIGHT_LOW) begin
            // head back toward sunrise, opposite to the net displacement
            sunrise_dir = (trk_disp >= 0);
            trk_disp    = 0;
            begin_rotation(sunrise_dir);
            started  = 1'b1;
            trk_mode = MODE_LOW;
          end else if (level != LIGHT_DARK) begin
            trk_mode = MODE_NORMAL;
          end
        end
      endcase
      if (!started) trk_sleep_left = set_sleep_ticks;
    end
    return '{trk_running, trk_dir, trk_lamp, trk_mode};
  endfunction

  function automatic void plan_ticks(input logic [LevelW-1:0] level, input logic two,
                                     input int unsigned count);
    plan_row_t row;
    row.kind  = ROW_TICKS;
    row.level = level;
    row.two   = two;
    row.count = count;
    row.typed = 1'b0;
    row.res   = '{1'b0, 1'b0, 1'b0, MODE_LOW};
    row.idx   = CFG_SLEEP_TICKS;
    row.data  = '0;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_status(input logic [LevelW-1:0] level, input logic two,
                                      input logic motor, input logic toward,
                                      input logic lamp, input mode_e mode);
    plan_ticks(level, two, 1);
    plan_q[$].typed = 1'b1;
    plan_q[$].res   = '{motor, toward, lamp, mode};
  endfunction

  function automatic void plan_reg(input logic [CfgIdxW-1:0] idx,
                                   input logic [CfgDataW-1:0] data);
    plan_ticks(LIGHT_DARK, 1'b0, 0);
    plan_q[$].kind = ROW_REG;
    plan_q[$].idx  = idx;
    plan_q[$].data = data;
  endfunction

  // Offer one tick, wait for its transaction, and queue the status it should produce.
  task automatic send_tick(input logic [LevelW-1:0] level, input logic two,
                           input logic typed, input result_t typed_res);
    result_t predicted;
    cfg_we_i <= 1'b0;
    while (!steady && $urandom_range(99) < 16) begin
      in_vld_i <= 1'b0;
      @(posedge clk_i);
    end
    in_vld_i          <= 1'b1;
    light_level_i     <= level;
    sun_on_cell_two_i <= two;
    do @(posedge clk_i); while (in_stall_o);
    predicted = track_tick(level, two);
    expected_status_q.push_back(typed ? typed_res : predicted);
    ticks_sent++;
  endtask

  task automatic hold_light(input logic [LevelW-1:0] level, input logic two,
                            input int unsigned count);
    repeat (count) send_tick(level, two, 1'b0, '{1'b0, 1'b0, 1'b0, MODE_LOW});
  endtask

  // Drain the block before touching a register; the write enable stays high
  // until the next tick, so back-to-back writes need not lower it in between.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    in_vld_i <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CFG_SLEEP_TICKS) set_sleep_ticks = data;
    else if (idx == CFG_MAX_STEPS) set_max_steps = data[StepW-1:0];
  endtask

  // Light level and sun side drift slowly so modes settle and rotations run;
  // a few single ticks of noise are mixed in.
  task automatic random_ticks(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(99) < 12) drift_level = LevelW'($urandom_range(3));
      if ($urandom_range(99) < 10) drift_two = ~drift_two;
      if ($urandom_range(99) < 8)
        send_tick(LevelW'($urandom_range(3)), 1'($urandom_range(1)), 1'b0,
                  '{1'b0, 1'b0, 1'b0, MODE_LOW});
      else
        send_tick(drift_level, drift_two, 1'b0, '{1'b0, 1'b0, 1'b0, MODE_LOW});
    end
  endtask

  task automatic check_status();
    result_t want;
    if (expected_status_q.size() == 0) begin
      $error("status transaction with no tick pending");
      errors++;
      return;
    end
    want = expected_status_q.pop_front();
    statuses_seen++;
    if (motor_on_o !== want.motor_on) begin
      $error("motor_on: expected %0b, got %0b", want.motor_on, motor_on_o);
      errors++;
    end
    if (motor_toward_two_o !== want.motor_toward_two) begin
      $error("motor_toward_two: expected %0b, got %0b", want.motor_toward_two,
             motor_toward_two_o);
      errors++;
    end
    if (lamp_on_o !== want.lamp_on) begin
      $error("lamp_on: expected %0b, got %0b", want.lamp_on, lamp_on_o);
      errors++;
    end
    if (panel_mode_o !== want.panel_mode) begin
      $error("panel_mode: expected %0d, got %0d", want.panel_mode, panel_mode_o);
      errors++;
    end
  endtask

  // Status side: random stalls plus one long hold-off that backs up the input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_vld_o && !out_stall_i) check_status();
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (!held_once && statuses_seen >= HOLD_OFF_AFTER) begin
        out_stall_i <= 1'b1;
        hold_left   <= HOLD_OFF_CYCLES;
        held_once   <= 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < 16);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_vld_i && !in_stall_o) || (out_vld_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [CfgDataW-1:0] sleep_pick;
    logic [CfgDataW-1:0] steps_pick;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_SLEEP_TICKS;
    cfg_data_i        = '0;
    in_vld_i          = 1'b0;
    light_level_i     = LIGHT_DARK;
    sun_on_cell_two_i = 1'b0;
    out_stall_i       = 1'b0;
    errors            = 0;
    ticks_sent        = 0;
    statuses_seen     = 0;
    rotations         = 0;
    quiet_cycles      = 0;
    hold_left         = 0;
    held_once         = 1'b0;
    steady            = 1'b0;
    drift_level       = LIGHT_NORMAL;
    drift_two         = 1'b0;

    set_sleep_ticks = SleepTicksRst;
    set_max_steps   = MaxStepsRst;
    trk_mode        = MODE_NORMAL;
    trk_running     = 1'b0;
    trk_dir         = 1'b0;
    trk_lamp        = 1'b1;
    trk_steps_left  = '0;
    trk_steps_done  = '0;
    trk_disp        = 0;
    trk_sleep_left  = '0;

    // Reset values: the first tick evaluates at once and starts a rotation
    // toward cell two; a flip of the sun side ends it after a few steps.
    plan_status(LIGHT_NORMAL, 1'b1, 1'b1, 1'b1, 1'b0, MODE_NORMAL);
    plan_ticks(LIGHT_NORMAL, 1'b1, 5);
    plan_reg(CFG_SLEEP_TICKS, 16'd0);
    plan_reg(CFG_MAX_STEPS, 16'd2);
    plan_reg(CFG_SPARE_LO, 16'hFFFF);
    plan_reg(CFG_SPARE_HI, 16'hFFFF);
    plan_ticks(LIGHT_NORMAL, 1'b0, 1);
    // dark mode, then sunrise return with a negative displacement
    plan_ticks(LIGHT_DARK, 1'b0, 1);
    plan_ticks(LIGHT_DARK, 1'b1, 1);
    plan_ticks(LIGHT_LOW, 1'b0, 1);
    plan_ticks(LIGHT_DARK, 1'b1, 1);
    plan_ticks(LIGHT_LOW, 1'b1, 1);
    // level three acts as normal light, in low mode and while rotating
    plan_ticks(LIGHT_BRIGHT, 1'b1, 2);
    plan_ticks(LIGHT_BRIGHT, 1'b0, 1);
    plan_ticks(LIGHT_LOW, 1'b0, 2);
    plan_ticks(LIGHT_DARK, 1'b0, 1);
    // sunrise return with a positive displacement, steps run out
    plan_ticks(LIGHT_LOW, 1'b0, 1);
    plan_ticks(LIGHT_NORMAL, 1'b1, 2);
    plan_ticks(LIGHT_NORMAL, 1'b0, 1);
    // zero max_steps: the rotation ends in the tick that starts it
    plan_reg(CFG_MAX_STEPS, 16'h0000);
    plan_status(LIGHT_NORMAL, 1'b1, 1'b0, 1'b1, 1'b0, MODE_NORMAL);
    plan_reg(CFG_SLEEP_TICKS, 16'd2);
    plan_reg(CFG_MAX_STEPS, 16'hF003);
    plan_ticks(LIGHT_NORMAL, 1'b0, 4);
    plan_ticks(LIGHT_DARK, 1'b0, 3);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_REG)
        write_reg(plan_q[i].idx, plan_q[i].data);
      else
        repeat (plan_q[i].count)
          send_tick(plan_q[i].level, plan_q[i].two, plan_q[i].typed, plan_q[i].res);
    end

    // The full-scale max_steps phase comes last so its long rotation runs
    // straight into the back-to-back stretch.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        1: begin
          sleep_pick = 16'd1;
          steps_pick = 16'd0;
        end
        2: begin
          sleep_pick = 16'd0;
          steps_pick = 16'd1;
        end
        RANDOM_PHASES - 1: begin
          sleep_pick = 16'd0;
          steps_pick = 16'hFFFF;
        end
        default: begin
          sleep_pick = CfgDataW'($urandom_range(4));
          steps_pick = {4'($urandom_range(15)), 12'($urandom_range(12))};
        end
      endcase
      write_reg(CFG_SLEEP_TICKS, sleep_pick);
      write_reg(CFG_MAX_STEPS, steps_pick);
      write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                CfgDataW'($urandom_range(16'hFFFF)));
      random_ticks(PHASE_TICKS);
    end

    // Back-to-back stretch: long runs of normal light in each direction with
    // a trip through dark mode and a sunrise return between them.
    steady = 1'b1;
    write_reg(CFG_SLEEP_TICKS, 16'd0);
    write_reg(CFG_MAX_STEPS, 16'd12);
    hold_light(LIGHT_NORMAL, 1'b0, STEADY_TICKS);
    hold_light(LIGHT_NORMAL, 1'b1, 1);
    hold_light(LIGHT_DARK, 1'b0, 2);
    hold_light(LIGHT_LOW, 1'b0, 1);
    hold_light(LIGHT_NORMAL, 1'b1, STEADY_TICKS);
    hold_light(LIGHT_NORMAL, 1'b0, 1);
    hold_light(LIGHT_DARK, 1'b1, 2);
    hold_light(LIGHT_LOW, 1'b1, 1);
    hold_light(LIGHT_NORMAL, 1'b0, 3);
    steady = 1'b0;

    write_reg(CFG_SLEEP_TICKS, 16'hFFFF);
    write_reg(CFG_MAX_STEPS, 16'd1);
    random_ticks(PHASE_TICKS);

    in_vld_i <= 1'b0;
    cfg_we_i <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d ticks with %0d rotations: reset values, all light levels and modes,",
             ticks_sent, rotations);
    $display("spare register writes, zero and full-scale settings, a long output stall.");
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
